[hw/rtl/wgm_pkg.sv]
package wgm_pkg;

   localparam logic [7:0] STAR_CHAR  = 8'h2A;
   localparam logic [7:0] QMARK_CHAR = 8'h3F;
   localparam logic [7:0] LOWER_A    = 8'h61;
   localparam logic [7:0] LOWER_Z    = 8'h7A;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   localparam logic REQ_PATTERN = 1'b0;
   localparam logic REQ_SUBJECT = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] char_value;
      logic       is_end;
      logic       ignore_case;
   } wgm_req_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } wgm_rsp_type;

   typedef struct packed {
      logic       store;
      logic       rearm;
      logic       step;
      logic       fold;
      logic [7:0] data_char;
   } wgm_ctl_type;

endpackage

[hw/rtl/wildcard_glob_matcher_core.sv]
// Glob matcher for '*' (any run, also empty) and '?' (any one byte). Send the pattern as
// pattern items closed by a pattern end item, which also latches the case-folding choice,
// then send each subject as subject bytes closed by a subject end item; only the subject
// end gives a result transfer, carrying matched and pattern_overflow. No input item holds
// the core busy: the pattern lives in a chain of MAX_PATTERN cells, one per position, each
// holding its byte and its active bit, and the closure over stars ripples along the chain
// within the same cycle as the step. The input stalls only while a result
// waits in the output register and rsp_stall is high. Patterns longer than MAX_PATTERN
// bytes set pattern_overflow and every match is reported false.
module wildcard_glob_matcher_core #(
   parameter int MAX_PATTERN = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  wgm_pkg::wgm_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output wgm_pkg::wgm_rsp_type rsp_data
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

   logic [LEN_W-1:0]     length_ff, length_in;
   logic                 closed_ff, closed_in;
   logic                 fold_ff, fold_in;
   logic                 ovf_ff, ovf_in;
   logic                 tail_raw_ff, tail_raw_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   wgm_pkg::wgm_rsp_type rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 pat_item;
   logic                 subj_char;
   logic                 subj_end;
   logic [LEN_W-1:0]     base_len;
   logic                 base_ovf;
   logic                 full;
   logic                 tail_closed;
   logic                 tail_hit;
   wgm_pkg::wgm_ctl_type ctl;

   logic [MAX_PATTERN:0]   closed_chain;
   logic [MAX_PATTERN:0]   hand_chain;
   logic [MAX_PATTERN-1:0] end_hits;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign pat_item  = accept & (req_data.req_type == wgm_pkg::REQ_PATTERN);
   assign subj_char = accept & (req_data.req_type == wgm_pkg::REQ_SUBJECT) & ~req_data.is_end;
   assign subj_end  = accept & (req_data.req_type == wgm_pkg::REQ_SUBJECT) & req_data.is_end;

   assign base_len = closed_ff ? '0 : length_ff;
   assign base_ovf = closed_ff ? 1'b0 : ovf_ff;
   assign full     = base_len == MAX_LEN;

   always_comb begin
      ctl.store     = pat_item & ~req_data.is_end & ~full;
      ctl.rearm     = pat_item | subj_end;
      ctl.step      = subj_char;
      ctl.fold      = fold_ff;
      ctl.data_char = req_data.char_value;
   end

   assign closed_chain[0] = 1'b0;
   assign hand_chain[0]   = 1'b0;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      wgm_cell #(
         .INDEX (i),
         .LEN_W (LEN_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .store_index (base_len),
         .length      (length_ff),
         .closed_in   (closed_chain[i]),
         .hand_in     (hand_chain[i]),
         .closed_out  (closed_chain[i+1]),
         .hand_out    (hand_chain[i+1]),
         .end_hit     (end_hits[i])
      );
   end

   assign tail_closed = tail_raw_ff | closed_chain[MAX_PATTERN];
   assign tail_hit    = tail_closed & (length_ff == MAX_LEN);

   always_comb begin
      length_in    = length_ff;
      closed_in    = closed_ff;
      fold_in      = fold_ff;
      ovf_in       = ovf_ff;
      tail_raw_in  = tail_raw_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (pat_item) begin
         closed_in = req_data.is_end;
         if (req_data.is_end) begin
            fold_in   = req_data.ignore_case;
            length_in = base_len;
            ovf_in    = base_ovf;
         end else if (full) begin
            length_in = base_len;
            ovf_in    = 1'b1;
         end else begin
            length_in = base_len + LEN_W'(1);
            ovf_in    = base_ovf;
         end
      end
      if (ctl.rearm) begin
         tail_raw_in = 1'b0;
      end else if (subj_char) begin
         tail_raw_in = hand_chain[MAX_PATTERN];
      end
      if (subj_end) begin
         rsp_valid_in                 = 1'b1;
         rsp_data_in.matched          = ((|end_hits) | tail_hit) & ~ovf_ff;
         rsp_data_in.pattern_overflow = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         closed_ff    <= 1'b1;
         fold_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         tail_raw_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         closed_ff    <= closed_in;
         fold_ff      <= fold_in;
         ovf_ff       <= ovf_in;
         tail_raw_ff  <= tail_raw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_ovf_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.pattern_overflow |-> !rsp_data_ff.matched)
      else $error("A result with pattern overflow reports a match.");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= MAX_LEN)
      else $error("Pattern length exceeds the store.");

   a_rearm_tail: assert property (@(posedge clock) disable iff (reset)
      ctl.rearm |=> !tail_raw_ff)
      else $error("Final position stays active after the set is re-armed.");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("Input stalls while no result is waiting.");

endmodule

[hw/rtl/wgm_cell.sv]
module wgm_cell #(
   parameter int INDEX = 0,
   parameter int LEN_W = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  wgm_pkg::wgm_ctl_type ctl,
   input  logic [LEN_W-1:0]    store_index,
   input  logic [LEN_W-1:0]    length,
   input  logic                closed_in,
   input  logic                hand_in,
   output logic                closed_out,
   output logic                hand_out,
   output logic                end_hit
);

   localparam logic [LEN_W-1:0] POS = LEN_W'(INDEX);

   logic [7:0] char_ff;
   logic       raw_ff;
   logic       raw_in;
   logic       valid;
   logic       is_star;
   logic       closed;
   logic       match;
   logic [7:0] fold_p;
   logic [7:0] fold_c;

   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      if (c >= wgm_pkg::LOWER_A && c <= wgm_pkg::LOWER_Z) begin
         return c - wgm_pkg::CASE_BIT;
      end
      return c;
   endfunction

   assign valid   = POS < length;
   assign is_star = char_ff == wgm_pkg::STAR_CHAR;
   assign closed  = raw_ff | closed_in;
   assign fold_p  = fold_upper(char_ff);
   assign fold_c  = fold_upper(ctl.data_char);
   assign match   = (char_ff == wgm_pkg::QMARK_CHAR) || (char_ff == ctl.data_char) ||
                    (ctl.fold && (fold_p == fold_c));

   assign closed_out = closed & valid & is_star;
   assign hand_out   = closed & valid & ~is_star & match;
   assign end_hit    = closed & (length == POS);

   always_comb begin
      raw_in = raw_ff;
      if (ctl.rearm) begin
         raw_in = (INDEX == 0);
      end else if (ctl.step) begin
         raw_in = (closed & valid & is_star) | hand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff <= (INDEX == 0);
      end else begin
         raw_ff <= raw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.store && store_index == POS) begin
         char_ff <= ctl.data_char;
      end
   end

endmodule
